@@ rtl/dtd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the DER TLV decoder.
// No dependencies; imported by dtd_core, dtd_out_reg, der_tlv_decoder_unit, der_tlv_checker and tb.
package dtd_pkg;

	localparam int unsigned DefLengthBytes = 4;
	localparam logic [7:0]  IndefByte      = 8'h80;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_LEN_FIRST = 5'b00010,
		PH_LEN_MORE  = 5'b00100,
		PH_CONTENT   = 5'b01000,
		PH_DEAD      = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CONTENT = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NEED_MORE    = 3'd0,
		ERR_BAD_TAG      = 3'd1,
		ERR_INDEFINITE   = 3'd2,
		ERR_LEN_TOO_LONG = 3'd3,
		ERR_LEN_OVERRUN  = 3'd4,
		ERR_CONT_OVERRUN = 3'd5
	} err_t;

	typedef struct packed {
		logic        last;
		err_t        error_code;
		logic [31:0] content_length;
		logic [7:0]  value_byte;
		kind_t       kind;
	} res_t;

endpackage

@@ rtl/dtd_core.sv @@
`timescale 1ns / 1ps
// Parser state and combinational step logic of the DER TLV decoder.
// Depends on dtd_pkg.
module dtd_core import dtd_pkg::*; #(
	parameter int unsigned MAX_LEN_OCTETS = DefLengthBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        start_req,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  want_tag,
	input  logic [31:0] avail_len,
	output logic        res_valid,
	output res_t        res
);

	localparam int unsigned LbW = $clog2(MAX_LEN_OCTETS + 1);

	phase_t          phase_q, phase_n;
	logic [LbW-1:0]  lbl_q, lbl_n;
	logic [31:0]     acc_q, acc_n;
	logic [31:0]     bl_q, bl_n;
	logic [31:0]     cl_q, cl_n;
	logic            ovf_q, ovf_n;

	logic            do_fail;
	err_t            fail_code;
	logic            do_hdr;
	logic [31:0]     hdr_len;
	logic            do_byte;
	logic [6:0]      n_len;

	always_comb begin
		phase_n   = phase_q;
		lbl_n     = lbl_q;
		acc_n     = acc_q;
		bl_n      = bl_q;
		cl_n      = cl_q;
		ovf_n     = ovf_q;
		do_fail   = 1'b0;
		fail_code = ERR_NEED_MORE;
		do_hdr    = 1'b0;
		hdr_len   = '0;
		do_byte   = 1'b0;
		n_len     = byte_value[6:0];
		if (start_req) begin
			lbl_n = '0;
			acc_n = '0;
			cl_n  = '0;
			ovf_n = 1'b0;
			bl_n  = '0;
			if (avail_len == 32'd0) begin
				do_fail = 1'b1;
			end else if (byte_value != want_tag) begin
				do_fail   = 1'b1;
				fail_code = ERR_BAD_TAG;
			end else begin
				bl_n = avail_len - 32'd1;
				if (avail_len == 32'd1)
					do_fail = 1'b1;
				else
					phase_n = PH_LEN_FIRST;
			end
		end else begin
			unique case (phase_q)
				PH_LEN_FIRST: begin
					bl_n = bl_q - 32'd1;
					if (byte_value == IndefByte) begin
						do_fail   = 1'b1;
						fail_code = ERR_INDEFINITE;
					end else if (!byte_value[7]) begin
						if ({24'd0, byte_value} > bl_n) begin
							do_fail   = 1'b1;
							fail_code = ERR_CONT_OVERRUN;
						end else begin
							do_hdr  = 1'b1;
							hdr_len = {24'd0, byte_value};
						end
					end else if (n_len > 7'(MAX_LEN_OCTETS)) begin
						do_fail   = 1'b1;
						fail_code = ERR_LEN_TOO_LONG;
					end else if ({25'd0, n_len} > bl_n) begin
						do_fail   = 1'b1;
						fail_code = ERR_LEN_OVERRUN;
					end else begin
						lbl_n   = LbW'(n_len);
						acc_n   = '0;
						ovf_n   = 1'b0;
						phase_n = PH_LEN_MORE;
					end
				end
				PH_LEN_MORE: begin
					ovf_n = ovf_q | (acc_q[31:24] != 8'd0);
					acc_n = {acc_q[23:0], byte_value};
					if (bl_q != 32'd0)
						bl_n = bl_q - 32'd1;
					if (lbl_q != '0)
						lbl_n = lbl_q - LbW'(1);
					if (lbl_n == '0) begin
						if (ovf_n || acc_n > bl_n) begin
							do_fail   = 1'b1;
							fail_code = ERR_CONT_OVERRUN;
						end else begin
							do_hdr  = 1'b1;
							hdr_len = acc_n;
						end
					end
				end
				PH_CONTENT: begin
					if (cl_q != 32'd0)
						cl_n = cl_q - 32'd1;
					if (bl_q != 32'd0)
						bl_n = bl_q - 32'd1;
					do_byte = 1'b1;
					if (cl_n == 32'd0)
						phase_n = PH_IDLE;
				end
				default: ;
			endcase
		end

		res_valid = do_fail | do_hdr | do_byte;
		res       = '0;
		if (do_fail) begin
			phase_n        = PH_DEAD;
			res.kind       = KIND_ERROR;
			res.error_code = fail_code;
			res.last       = 1'b1;
		end else if (do_hdr) begin
			res.kind           = KIND_HEADER;
			res.content_length = hdr_len;
			if (hdr_len == 32'd0) begin
				phase_n  = PH_IDLE;
				res.last = 1'b1;
			end else begin
				cl_n    = hdr_len;
				phase_n = PH_CONTENT;
			end
		end else if (do_byte) begin
			res.kind       = KIND_CONTENT;
			res.value_byte = byte_value;
			res.last       = (cl_n == 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lbl_q   <= '0;
			acc_q   <= '0;
			bl_q    <= '0;
			cl_q    <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			lbl_q   <= lbl_n;
			acc_q   <= acc_n;
			bl_q    <= bl_n;
			cl_q    <= cl_n;
			ovf_q   <= ovf_n;
		end
	end

	a_start_only_errors: assert property (@(posedge clk) disable iff (!arst_n)
		step && start_req && res_valid |-> res.kind == KIND_ERROR)
		else $error("start item produced a non-error result");

	a_error_kills: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.kind == KIND_ERROR |=> phase_q == PH_DEAD)
		else $error("parser not dead after error");

	a_lbl_in_len_more: assert property (@(posedge clk) disable iff (!arst_n)
		lbl_q != '0 |-> phase_q == PH_LEN_MORE)
		else $error("length bytes pending outside length phase");

	a_content_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONTENT |-> cl_q != 32'd0)
		else $error("content phase with nothing left");

endmodule

@@ rtl/dtd_out_reg.sv @@
`timescale 1ns / 1ps
// Result register of the DER TLV decoder, drives the master stream side.
// Depends on dtd_pkg.
module dtd_out_reg import dtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	output logic        ready,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // value_byte, content_length, error_code, zero pad
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // last
);

	res_t res_q;

	assign ready = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ready) begin
			m_axis_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load)
			res_q <= res;
	end

	assign m_axis_tdata = {5'd0, res_q.error_code, res_q.content_length, res_q.value_byte};
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tlast = res_q.last;

endmodule

@@ rtl/der_tlv_decoder_unit.sv @@
`timescale 1ns / 1ps
// DER TLV decoder, top level: input register, parser core, result register.
// Depends on dtd_pkg, dtd_core and dtd_out_reg.

// One DER byte per item, one item per cycle; items are registered on input and results
// again on output. An item with tuser set opens an element: its byte is the tag,
// checked against the required tag, and avail_len counts the bytes left in the buffer
// including it. The length follows in short or long form (at most MAX_LEN_OCTETS
// length bytes); a header item (kind 1) gives the content length, then each content
// byte comes out as kind 0, tlast on the final one. An error (kind 2) ends the element
// and later bytes give nothing until the next start. Bytes that cause no result are
// consumed silently. The input takes an item every cycle unless a result is held
// back on the master side.
module der_tlv_decoder_unit import dtd_pkg::*; #(
	parameter int unsigned MAX_LEN_OCTETS = DefLengthBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // byte_value, want_tag, avail_len
	input  logic        s_axis_tuser,  // start_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // value_byte, content_length, error_code, zero pad
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // last
);

	logic        valid_s1;
	logic        start_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  tag_s1;
	logic [31:0] avail_s1;

	logic        out_ready;
	logic        step;
	logic        res_valid;
	res_t        res;

	assign step          = valid_s1 && out_ready;
	assign s_axis_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			start_s1 <= s_axis_tuser;
			byte_s1  <= s_axis_tdata[7:0];
			tag_s1   <= s_axis_tdata[15:8];
			avail_s1 <= s_axis_tdata[47:16];
		end
	end

	dtd_core #(
		.MAX_LEN_OCTETS(MAX_LEN_OCTETS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.start_req   (start_s1),
		.byte_value  (byte_s1),
		.want_tag    (tag_s1),
		.avail_len   (avail_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	dtd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && res_valid),
		.res          (res),
		.ready        (out_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

@@ tb/der_tlv_checker.sv @@
`timescale 1ns / 1ps
// Result checker for der_tlv_decoder_unit: predicts the decoder from accepted
// input items and compares every accepted output item with the oldest prediction.
// Depends on dtd_pkg for the phase, kind, error and result types.
module der_tlv_checker import dtd_pkg::*; #(
	parameter int unsigned MAX_LEN_OCTETS = DefLengthBytes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          outstanding,
	output int          fail_count,
	output int          results_seen
);

	phase_t      parse_phase;
	logic [3:0]  len_left;
	logic [31:0] len_acc;
	logic [31:0] buf_left;
	logic [31:0] body_left;
	logic        len_ovf;
	res_t        tlv_results_q[$];
	int          fails;
	int          seen;

	function automatic res_t make_res(kind_t k, logic [7:0] vb, logic [31:0] clen, err_t e,
	                                  logic l);
		res_t r;
		r.kind           = k;
		r.value_byte     = vb;
		r.content_length = clen;
		r.error_code     = e;
		r.last           = l;
		return r;
	endfunction

	function void abort_element(err_t e);
		parse_phase = PH_DEAD;
		tlv_results_q.push_back(make_res(KIND_ERROR, 8'h00, 32'h0, e, 1'b1));
	endfunction

	function void open_content(logic [31:0] clen);
		if (clen == 32'h0) begin
			parse_phase = PH_IDLE;
			tlv_results_q.push_back(make_res(KIND_HEADER, 8'h00, 32'h0, ERR_NEED_MORE, 1'b1));
		end else begin
			body_left   = clen;
			parse_phase = PH_CONTENT;
			tlv_results_q.push_back(make_res(KIND_HEADER, 8'h00, clen, ERR_NEED_MORE, 1'b0));
		end
	endfunction

	function void decode_byte(logic st, logic [7:0] b, logic [7:0] tag, logic [31:0] avail);
		logic [31:0] n;
		if (st) begin
			len_left  = 4'd0;
			len_acc   = 32'h0;
			body_left = 32'h0;
			len_ovf   = 1'b0;
			buf_left  = 32'h0;
			if (avail == 32'h0) begin
				abort_element(ERR_NEED_MORE);
			end else if (b != tag) begin
				abort_element(ERR_BAD_TAG);
			end else begin
				buf_left = avail - 32'd1;
				if (buf_left == 32'h0)
					abort_element(ERR_NEED_MORE);
				else
					parse_phase = PH_LEN_FIRST;
			end
			return;
		end
		case (parse_phase)
			PH_LEN_FIRST: begin
				buf_left = buf_left - 32'd1;
				n = {25'h0, b[6:0]};
				if (b == IndefByte) begin
					abort_element(ERR_INDEFINITE);
				end else if (!b[7]) begin
					if ({24'h0, b} > buf_left)
						abort_element(ERR_CONT_OVERRUN);
					else
						open_content({24'h0, b});
				end else if (n > MAX_LEN_OCTETS) begin
					abort_element(ERR_LEN_TOO_LONG);
				end else if (n > buf_left) begin
					abort_element(ERR_LEN_OVERRUN);
				end else begin
					len_left    = n[3:0];
					len_acc     = 32'h0;
					len_ovf     = 1'b0;
					parse_phase = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				if (len_acc[31:24] != 8'h00)
					len_ovf = 1'b1;
				len_acc = {len_acc[23:0], b};
				if (buf_left != 32'h0)
					buf_left = buf_left - 32'd1;
				if (len_left != 4'd0)
					len_left = len_left - 4'd1;
				if (len_left == 4'd0) begin
					if (len_ovf || len_acc > buf_left)
						abort_element(ERR_CONT_OVERRUN);
					else
						open_content(len_acc);
				end
			end
			PH_CONTENT: begin
				if (body_left != 32'h0)
					body_left = body_left - 32'd1;
				if (buf_left != 32'h0)
					buf_left = buf_left - 32'd1;
				if (body_left == 32'h0) begin
					parse_phase = PH_IDLE;
					tlv_results_q.push_back(make_res(KIND_CONTENT, b, 32'h0, ERR_NEED_MORE, 1'b1));
				end else begin
					tlv_results_q.push_back(make_res(KIND_CONTENT, b, 32'h0, ERR_NEED_MORE, 1'b0));
				end
			end
			default: ;
		endcase
	endfunction

	function automatic bit field_differs(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		bit   bad;
		if (!arst_n) begin
			parse_phase = PH_IDLE;
			len_left    = 4'd0;
			len_acc     = 32'h0;
			buf_left    = 32'h0;
			body_left   = 32'h0;
			len_ovf     = 1'b0;
			tlv_results_q.delete();
			fails        = 0;
			seen         = 0;
			outstanding  <= 0;
			fail_count   <= 0;
			results_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen++;
				if (tlv_results_q.size() == 0) begin
					$display("%0t: unexpected item kind %0h tdata %0h last %0b", $time,
					         m_axis_tuser, m_axis_tdata, m_axis_tlast);
					fails++;
				end else begin
					want = tlv_results_q.pop_front();
					bad  = 1'b0;
					bad |= field_differs("kind", want.kind, m_axis_tuser);
					bad |= field_differs("value_byte", want.value_byte, m_axis_tdata[7:0]);
					bad |= field_differs("content_length", want.content_length,
					                     m_axis_tdata[39:8]);
					bad |= field_differs("error_code", want.error_code, m_axis_tdata[42:40]);
					bad |= field_differs("last", want.last, m_axis_tlast);
					if (bad)
						fails++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
				            s_axis_tdata[47:16]);
			outstanding  <= tlv_results_q.size();
			fail_count   <= fails;
			results_seen <= seen;
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for der_tlv_decoder_unit: clock, reset, DER byte stimulus and verdict.
// Depends on dtd_pkg, der_tlv_decoder_unit and der_tlv_checker.
module tb;
	import dtd_pkg::*;

	localparam int ITEM_TARGET = 550;
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_LEN_OCTETS = DefLengthBytes;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          outstanding;
	int          fail_count;
	int          results_seen;
	int          send_idle;
	int          recv_idle;
	int          items_sent;
	int          elements_sent;
	int unsigned cycles = 0;
	logic [7:0]  elem_q[$];

	der_tlv_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	der_tlv_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.outstanding   (outstanding),
		.fail_count    (fail_count),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	task automatic put_byte(input logic st, input logic [7:0] b, input logic [7:0] tag,
	                        input logic [31:0] avail);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= st;
		s_axis_tdata  <= {avail, tag, b};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_element(input logic [7:0] tag, input logic [31:0] avail);
		int i;
		for (i = 0; i < elem_q.size(); i++) begin
			if (i == 0)
				put_byte(1'b1, elem_q[i], tag, avail);
			else
				put_byte(1'b0, elem_q[i], 8'($urandom), $urandom);
		end
		items_sent += elem_q.size();
		elements_sent++;
		elem_q.delete();
	endtask

	task automatic send_noise(input int unsigned n);
		repeat (n) put_byte(1'b0, 8'($urandom), 8'($urandom), $urandom);
	endtask

	function automatic void put_length(int unsigned nlen, logic [31:0] val);
		int i;
		if (nlen == 0) begin
			elem_q.push_back({1'b0, val[6:0]});
		end else begin
			elem_q.push_back(IndefByte | 8'(nlen));
			for (i = nlen; i > 0; i--)
				elem_q.push_back((i > 4) ? 8'h00 : val[8 * (i - 1) +: 8]);
		end
	endfunction

	function automatic void put_body(int unsigned n);
		repeat (n) elem_q.push_back(8'($urandom));
	endfunction

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_element;
		int unsigned sel;
		int unsigned clen;
		int unsigned nlen;
		int unsigned k;
		logic [7:0]  tag;
		logic [31:0] avail;
		logic [31:0] val;
		sel   = $urandom_range(99);
		tag   = 8'($urandom);
		avail = $urandom;
		if (sel < 55) begin
			clen = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10);
			nlen = $urandom_range(1) ? 0 : $urandom_range(4, 1);
			elem_q.push_back(tag);
			put_length(nlen, clen);
			put_body(clen);
			if ($urandom_range(7) == 0) begin
				if (avail < elem_q.size())
					avail = elem_q.size();
			end else begin
				avail = elem_q.size() + $urandom_range(3);
			end
		end else if (sel < 63) begin
			avail = $urandom | 32'h0000_0100;
			nlen  = $urandom_range(4, 1);
			val   = $urandom_range(avail - 6, 0);
			val   = val >> (8 * (4 - nlen));
			elem_q.push_back(tag);
			put_length(nlen, val);
			put_body((val < 4) ? val : $urandom_range(3));
		end else if (sel < 75) begin
			elem_q.push_back(tag);
			case ($urandom_range(2))
				0: begin
					clen  = $urandom_range(127, 1);
					put_length(0, clen);
					avail = $urandom_range(clen + 1, 2);
				end
				1: begin
					nlen  = $urandom_range(4, 1);
					val   = ($urandom >> (8 * (4 - nlen))) | 32'h1;
					put_length(nlen, val);
					avail = 2 + nlen + $urandom_range(val - 1, 0);
				end
				default: begin
					nlen  = $urandom_range(4, 1);
					put_length(nlen, $urandom);
					avail = $urandom_range(nlen + 1, 2);
				end
			endcase
			put_body($urandom_range(2));
		end else if (sel < 82) begin
			case ($urandom_range(3))
				0: begin
					elem_q.push_back(tag);
					elem_q.push_back(IndefByte);
					avail = avail | 32'h2;
				end
				1: begin
					elem_q.push_back(tag);
					elem_q.push_back(IndefByte | 8'($urandom_range(127, MAX_LEN_OCTETS + 1)));
				end
				2: begin
					elem_q.push_back(tag);
					avail = $urandom_range(1);
				end
				default: begin
					elem_q.push_back(tag ^ 8'($urandom_range(255, 1)));
					put_length(0, $urandom_range(5));
				end
			endcase
			put_body($urandom_range(2));
		end else if (sel < 90) begin
			elem_q.push_back(tag);
			put_length($urandom_range(4, 1), $urandom);
			k      = $urandom_range(elem_q.size() - 2, 1);
			while (elem_q.size() > k + 1)
				void'(elem_q.pop_back());
			avail  = avail | 32'h0000_0100;
		end else begin
			send_noise($urandom_range(3, 1));
		end
		if (elem_q.size() != 0)
			send_element(tag, avail);
	endtask

	initial begin
		int p;
		int target;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		send_idle     = 24;
		recv_idle     = 55;
		items_sent    = 0;
		elements_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		elem_q = '{8'h30};
		send_element(8'h30, 32'd0);
		elem_q = '{8'h00};
		send_element(8'hFF, 32'd5);
		elem_q = '{8'hFF};
		send_element(8'hFF, 32'd1);
		elem_q = '{8'h30, 8'h00};
		send_element(8'h30, 32'd2);
		elem_q = '{8'h04, 8'h01, 8'hFF};
		send_element(8'h04, 32'd3);
		elem_q = '{8'h30, IndefByte};
		send_element(8'h30, 32'd9);
		elem_q = '{8'h30, IndefByte | 8'h05};
		send_element(8'h30, 32'd100);
		elem_q = '{8'h02, IndefByte | 8'h02};
		send_element(8'h02, 32'd3);
		elem_q = '{8'h30, 8'h05};
		send_element(8'h30, 32'd3);
		elem_q = '{8'h30, IndefByte | 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_element(8'h30, 32'hFFFF_FFFF);
		elem_q = '{8'h30, IndefByte | 8'h01, 8'h01, 8'h00};
		send_element(8'h30, 32'd4);
		send_noise(1);

		for (p = 0; p < 3; p++) begin
			case (p)
				1: begin
					send_idle = 55;
					recv_idle = 24;
				end
				2: begin
					send_idle = 0;
					recv_idle = 0;
				end
				default: ;
			endcase
			target = ITEM_TARGET * (p + 1) / 3;
			while (items_sent < target)
				random_element();
			drain();
		end

		$display("Drove %0d items in %0d elements, %0d results compared", items_sent,
		         elements_sent, results_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
